>>> hw/rtl/modexp_pkg.sv
`timescale 1ns / 1ps

package modexp_pkg;

    localparam int WIDTH = 63;
    localparam int CNT_W = $clog2(WIDTH);
    localparam int IN_DATA_W = ((2 * WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((WIDTH + 7) / 8) * 8;

    typedef logic [WIDTH-1:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL,
        ST_SQR,
        ST_FINISH
    } state_t;

    typedef enum logic {
        SEL_ACC,
        SEL_BASE
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     mul_start;
        mul_sel_t start_sel;
        logic     mul_step;
        logic     commit;
        mul_sel_t commit_sel;
        logic     e_shift;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic e_zero;
        logic e_lsb;
        logic pb_zero;
    } status_t;

endpackage

>>> hw/rtl/modexp_dp.sv
`timescale 1ns / 1ps

module modexp_dp (
    input  logic                  clk,
    input  modexp_pkg::cmd_t      cmd,
    input  modexp_pkg::word_t     modulus,
    input  modexp_pkg::word_t     base_value,
    input  modexp_pkg::word_t     exponent,
    output modexp_pkg::status_t   status,
    output modexp_pkg::word_t     power_result
);
    import modexp_pkg::*;

    word_t            m_reg, m_next;
    word_t            x_reg, x_next;
    word_t            b_reg, b_next;
    word_t            e_reg, e_next;
    word_t            acc_reg, acc_next;
    word_t            padd_reg, padd_next;
    word_t            pb_reg, pb_next;
    word_t            pacc_reg, pacc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   m_ext;
    logic [WIDTH:0]   sum_acc;
    logic [WIDTH:0]   sum_dbl;
    word_t            start_src;

    assign m_ext     = {1'b0, m_reg};
    assign rem_sh    = {b_reg, x_reg[WIDTH-1]};
    assign sum_acc   = {1'b0, pacc_reg} + {1'b0, padd_reg};
    assign sum_dbl   = {padd_reg, 1'b0};
    assign start_src = (cmd.start_sel == SEL_BASE) ? b_reg : acc_reg;

    always_comb
    begin
        m_next    = m_reg;
        x_next    = x_reg;
        b_next    = b_reg;
        e_next    = e_reg;
        acc_next  = acc_reg;
        padd_next = padd_reg;
        pb_next   = pb_reg;
        pacc_next = pacc_reg;
        cnt_next  = cnt_reg;

        if (cmd.load)
        begin
            // a zero modulus behaves as a modulus of one
            m_next   = (modulus == '0) ? word_t'(1) : modulus;
            x_next   = base_value;
            b_next   = '0;
            e_next   = exponent;
            acc_next = word_t'(1);
            cnt_next = CNT_W'(WIDTH - 1);
        end

        // restoring remainder, one dividend bit per cycle
        if (cmd.div_step)
        begin
            if (rem_sh >= m_ext)
                b_next = word_t'(rem_sh - m_ext);
            else
                b_next = rem_sh[WIDTH-1:0];
            x_next   = {x_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
        end

        if (cmd.commit)
        begin
            if (cmd.commit_sel == SEL_BASE)
                b_next = pacc_reg;
            else
                acc_next = pacc_reg;
        end

        // the source is below the modulus except the initial one with modulus one
        if (cmd.mul_start)
        begin
            padd_next = (start_src >= m_reg) ? (start_src - m_reg) : start_src;
            pb_next   = b_reg;
            pacc_next = '0;
        end

        // add-and-double step over the multiplier bits
        if (cmd.mul_step)
        begin
            if (pb_reg[0])
            begin
                if (sum_acc >= m_ext)
                    pacc_next = word_t'(sum_acc - m_ext);
                else
                    pacc_next = sum_acc[WIDTH-1:0];
            end
            if (sum_dbl >= m_ext)
                padd_next = word_t'(sum_dbl - m_ext);
            else
                padd_next = sum_dbl[WIDTH-1:0];
            pb_next = {1'b0, pb_reg[WIDTH-1:1]};
        end

        if (cmd.e_shift)
            e_next = {1'b0, e_reg[WIDTH-1:1]};
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        x_reg    <= x_next;
        b_reg    <= b_next;
        e_reg    <= e_next;
        acc_reg  <= acc_next;
        padd_reg <= padd_next;
        pb_reg   <= pb_next;
        pacc_reg <= pacc_next;
        cnt_reg  <= cnt_next;
    end

    assign status.div_last = (cnt_reg == '0);
    assign status.e_zero   = (e_reg == '0);
    assign status.e_lsb    = e_reg[0];
    assign status.pb_zero  = (pb_reg == '0);
    assign power_result    = acc_reg;

endmodule

>>> hw/rtl/modexp_ctrl.sv
`timescale 1ns / 1ps

module modexp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_free,
    output logic                out_load,
    input  modexp_pkg::status_t status,
    output modexp_pkg::cmd_t    cmd
);
    import modexp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.start_sel  = SEL_ACC;
        cmd.commit_sel = SEL_ACC;
        in_ready       = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.e_zero)
                    state_next = ST_FINISH;
                else if (status.e_lsb)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.start_sel = SEL_ACC;
                    state_next    = ST_MUL;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.start_sel = SEL_BASE;
                    state_next    = ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (status.pb_zero)
                begin
                    // store the product and go straight on to the square
                    cmd.commit     = 1'b1;
                    cmd.commit_sel = SEL_ACC;
                    cmd.mul_start  = 1'b1;
                    cmd.start_sel  = SEL_BASE;
                    state_next     = ST_SQR;
                end
                else
                    cmd.mul_step = 1'b1;
            end
            ST_SQR:
            begin
                if (status.pb_zero)
                begin
                    cmd.commit     = 1'b1;
                    cmd.commit_sel = SEL_BASE;
                    cmd.e_shift    = 1'b1;
                    state_next     = ST_CHECK;
                end
                else
                    cmd.mul_step = 1'b1;
            end
            ST_FINISH:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/modular_exponentiation.sv
`timescale 1ns / 1ps

// Modular exponentiation: power_result = base_value ** exponent mod modulus.
// Input stream s_axis carries base_value and exponent; output stream m_axis
// carries one power_result per input transfer. The cfg channel writes the
// modulus (reset value 1, zero acts as one); write it only while idle.
// An item first reduces the base, one bit per cycle, then walks the exponent
// from its low bit: a check per bit, plus for a set bit an add-and-double
// product into the accumulator, plus a square of the base, both on the same
// add-and-double registers. A new item is accepted in the cycle after the
// previous result is loaded into the output register.
// The result sits in an output register: the next item is accepted and runs
// while it waits. If the receiver stalls, a finished result holds in the
// datapath until the output register frees up.
// Reset clears the controller and output valid and sets the modulus to 1.
module modular_exponentiation (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // base_value [62:0], exponent [125:63], zero pad
    input  logic [modexp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // power_result [62:0], zero pad
    output logic [modexp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [modexp_pkg::WIDTH-1:0]         cfg_data
);
    import modexp_pkg::*;

    word_t   modulus_reg;
    logic    out_valid_reg, out_valid_next;
    word_t   out_data_reg;
    logic    out_free;
    logic    out_load;
    cmd_t    cmd;
    status_t status;
    word_t   power_result;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= word_t'(1);
        else if (cfg_valid)
            modulus_reg <= cfg_data;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= power_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_data_reg);

    modexp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .out_load (out_load),
        .status   (status),
        .cmd      (cmd)
    );

    modexp_dp u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .modulus      (modulus_reg),
        .base_value   (s_axis_tdata[WIDTH-1:0]),
        .exponent     (s_axis_tdata[2*WIDTH-1:WIDTH]),
        .status       (status),
        .power_result (power_result)
    );

endmodule
